// ----- hdl/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg - shared types and constants for rotation matrix to quaternion
// Field widths, branch codes and the off-diagonal sum width.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FIELD_W = 18;
	localparam int FRAC_BITS_DEF = 16;

	// branch codes
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_M00 = 2'd1;
	localparam logic [1:0] BR_M11 = 2'd2;
	localparam logic [1:0] BR_M22 = 2'd3;

	// sums of off-diagonal pairs (19 bits signed)
	localparam int NUM_W = FIELD_W + 1;

endpackage

// ----- hdl/rmq_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt_cell - one step of a restoring square root
// Retires one result bit per cycle while enabled and hands the partial state down the chain.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
	parameter int RW = 36,
	parameter int QW = 18,
	parameter int DW = 64,
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [RW-1:0] rad_in,
	input  logic [QW-1:0] root_in,
	input  logic [RW-1:0] rem_in,
	input  logic [DW-1:0] side_in,
	output logic          vld_s1,
	output logic [RW-1:0] rad_s1,
	output logic [QW-1:0] root_s1,
	output logic [RW-1:0] rem_s1,
	output logic [DW-1:0] side_s1
);

	localparam int SH = RW - 2 - 2*STEP;

	logic [RW+1:0] cur;
	logic [RW+1:0] trial;
	logic          take;

	// bring in the next two radicand bits and try to subtract 4r+1
	always_comb begin
		cur = {rem_in, rad_in[SH +: 2]};
		trial = {root_in, 2'b01};
		take = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= rad_in;
			side_s1 <= side_in;
			root_s1 <= {root_in[QW-2:0], take};
			rem_s1 <= take ? RW'(cur - trial) : RW'(cur);
		end
	end

endmodule

// ----- hdl/rmq_div_cell.sv -----
// ----------------------------------------------------------------------------
// rmq_div_cell - one step of three parallel restoring dividers
// Shifts each dividend bit in, subtracts the shared divisor, hands on.
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; #(
	parameter int NW = 48,
	parameter int SW = 18,
	parameter int DW = 64,
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  logic [SW-1:0]       dvs_in,
	input  logic [2:0][NW-1:0]  num_in,
	input  logic [2:0][NW-1:0]  quo_in,
	input  logic [2:0][SW:0]    rem_in,
	input  logic [DW-1:0]       side_in,
	output logic                vld_s1,
	output logic [SW-1:0]       dvs_s1,
	output logic [2:0][NW-1:0]  num_s1,
	output logic [2:0][NW-1:0]  quo_s1,
	output logic [2:0][SW:0]    rem_s1,
	output logic [DW-1:0]       side_s1
);

	localparam int BIT = NW - 1 - STEP;

	logic [2:0][SW+1:0] cur;
	logic [2:0]         take;

	// three lanes share the divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur[i] = {rem_in[i], num_in[i][BIT]};
			take[i] = cur[i] >= {2'b00, dvs_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s1 <= dvs_in;
			num_s1 <= num_in;
			side_s1 <= side_in;
			for (int i = 0; i < 3; i++) begin
				quo_s1[i] <= {quo_in[i][NW-2:0], take[i]};
				rem_s1[i] <= take[i] ? (SW+1)'(cur[i] - {2'b00, dvs_in})
					: (SW+1)'(cur[i]);
			end
		end
	end

endmodule

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion - Shepperd rotation matrix to quaternion
// Chain of square root cells then chain of divider cells, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid in_ready m00..m22               | request in
//  out     | out_valid out_ready quat_x..w branch deg | result out
//
// One request per cycle while the output is not stalled. The pipeline is 1 input
// stage + QW root cells + 1 prepare stage + (FRAC_BITS+20) divider cells + 1
// output register; QW is 20 at FRAC_BITS=16.
// Reset clears only valid bits. A stalled output freezes the whole chain,
// so in_ready follows out_ready whenever the output register is full.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [FIELD_W-1:0] m00,
	input  logic signed [FIELD_W-1:0] m01,
	input  logic signed [FIELD_W-1:0] m02,
	input  logic signed [FIELD_W-1:0] m10,
	input  logic signed [FIELD_W-1:0] m11,
	input  logic signed [FIELD_W-1:0] m12,
	input  logic signed [FIELD_W-1:0] m20,
	input  logic signed [FIELD_W-1:0] m21,
	input  logic signed [FIELD_W-1:0] m22,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] quat_x,
	output logic signed [FIELD_W-1:0] quat_y,
	output logic signed [FIELD_W-1:0] quat_z,
	output logic signed [FIELD_W-1:0] quat_w,
	output logic [1:0]                branch_used,
	output logic                      degenerate
);

	// radicand a is ONE plus three entries, signed; shifted by FRAC_BITS+2, made even width
	localparam int AW = ((FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W) + 3;
	localparam int RW0 = AW + FRAC_BITS + 2;
	localparam int RW = RW0 + (RW0 % 2);
	localparam int QW = RW / 2;
	localparam int NSQ = RW / 2;
	localparam int MW = NUM_W;              // off-diagonal sum magnitude bits
	localparam int NW = MW + FRAC_BITS + 1;  // mag<<F plus s/2
	localparam int NDV = NW;
	localparam int SIDE_W = 2 + 3*NUM_W + 3;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: trace, branch, radicand, numerators
	logic signed [FIELD_W+1:0] tr;
	logic [1:0]                br;
	logic signed [AW-1:0]      a;
	logic signed [NUM_W-1:0]   na, nb, nc;
	logic signed [FIELD_W:0]   d21, d02, d10, s01, s02, s12;

	always_comb begin
		tr = (FIELD_W+2)'(m00) + (FIELD_W+2)'(m11) + (FIELD_W+2)'(m22);
		d21 = (FIELD_W+1)'(m21) - (FIELD_W+1)'(m12);
		d02 = (FIELD_W+1)'(m02) - (FIELD_W+1)'(m20);
		d10 = (FIELD_W+1)'(m10) - (FIELD_W+1)'(m01);
		s01 = (FIELD_W+1)'(m01) + (FIELD_W+1)'(m10);
		s02 = (FIELD_W+1)'(m02) + (FIELD_W+1)'(m20);
		s12 = (FIELD_W+1)'(m12) + (FIELD_W+1)'(m21);
		// lanes a,b,c hold the three non-diagonal components in x,y,z,w order
		if (tr > 0) begin
			br = BR_TRACE;
			a = AW'(tr) + AW'(1 << FRAC_BITS);
			na = d21; nb = d02; nc = d10;
		end else if (m00 > m11 && m00 > m22) begin
			br = BR_M00;
			a = AW'(1 << FRAC_BITS) + AW'(m00) - AW'(m11) - AW'(m22);
			na = s01; nb = s02; nc = d21;
		end else if (m11 > m22) begin
			br = BR_M11;
			a = AW'(1 << FRAC_BITS) + AW'(m11) - AW'(m00) - AW'(m22);
			na = s01; nb = s12; nc = d02;
		end else begin
			br = BR_M22;
			a = AW'(1 << FRAC_BITS) + AW'(m22) - AW'(m00) - AW'(m11);
			na = s02; nb = s12; nc = d10;
		end
	end

	logic                    v_s1;
	logic [RW-1:0]           rad_s1;
	logic [SIDE_W-1:0]       side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	// negative radicand clamps to zero
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= a[AW-1] ? '0
				: RW'({{(RW-AW){1'b0}}, a[AW-1:0]} << (FRAC_BITS + 2));
			side_s1 <= {br, na, nb, nc, 3'b000};
		end
	end

	// ---------------- square root chain
	logic [NSQ:0]                 sv;
	logic [NSQ:0][RW-1:0]         srad;
	logic [NSQ:0][QW-1:0]         sroot;
	logic [NSQ:0][RW-1:0]         srem;
	logic [NSQ:0][SIDE_W-1:0]     sside;

	assign sv[0] = v_s1;
	assign srad[0] = rad_s1;
	assign sroot[0] = '0;
	assign srem[0] = '0;
	assign sside[0] = side_s1;

	for (genvar g = 0; g < NSQ; g++) begin : g_sq
		rmq_sqrt_cell #(.RW(RW), .QW(QW), .DW(SIDE_W), .STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(sv[g]), .rad_in(srad[g]), .root_in(sroot[g]),
			.rem_in(srem[g]), .side_in(sside[g]),
			.vld_s1(sv[g+1]), .rad_s1(srad[g+1]), .root_s1(sroot[g+1]),
			.rem_s1(srem[g+1]), .side_s1(sside[g+1])
		);
	end

	// ---------------- prepare division: magnitudes, rounding bias, signs
	// S is the root of an RW-bit radicand, so the full root width holds it
	localparam int SW = QW;
	logic [QW-1:0] s_full;
	assign s_full = sroot[NSQ];

	logic [1:0]              br_t;
	logic signed [NUM_W-1:0] la, lb, lc;
	assign {br_t, la, lb, lc} = sside[NSQ][SIDE_W-1:3];

	logic                     v_s2;
	logic [SW-1:0]            s_s2;
	logic [2:0][NW-1:0]       num_s2;
	logic [SIDE_W-1:0]        side_s2;

	function automatic logic [NW-1:0] mag_biased(input logic signed [NUM_W-1:0] n,
		input logic [SW-1:0] s);
		logic [NUM_W-1:0] m;
		m = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
		return (NW'(m) << FRAC_BITS) + NW'(s >> 1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= sv[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= SW'(s_full);
			num_s2[0] <= mag_biased(la, SW'(s_full));
			num_s2[1] <= mag_biased(lb, SW'(s_full));
			num_s2[2] <= mag_biased(lc, SW'(s_full));
			side_s2 <= {br_t, la, lb, lc, la[NUM_W-1], lb[NUM_W-1], lc[NUM_W-1]};
		end
	end

	// ---------------- divider chain
	logic [NDV:0]                 dv;
	logic [NDV:0][SW-1:0]         ddvs;
	logic [NDV:0][2:0][NW-1:0]    dnum;
	logic [NDV:0][2:0][NW-1:0]    dquo;
	logic [NDV:0][2:0][SW:0]      drem;
	logic [NDV:0][SIDE_W-1:0]     dside;

	assign dv[0] = v_s2;
	assign ddvs[0] = s_s2;
	assign dnum[0] = num_s2;
	assign dquo[0] = '0;
	assign drem[0] = '0;
	assign dside[0] = side_s2;

	for (genvar g = 0; g < NDV; g++) begin : g_dv
		rmq_div_cell #(.NW(NW), .SW(SW), .DW(SIDE_W), .STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dv[g]), .dvs_in(ddvs[g]), .num_in(dnum[g]),
			.quo_in(dquo[g]), .rem_in(drem[g]), .side_in(dside[g]),
			.vld_s1(dv[g+1]), .dvs_s1(ddvs[g+1]), .num_s1(dnum[g+1]),
			.quo_s1(dquo[g+1]), .rem_s1(drem[g+1]), .side_s1(dside[g+1])
		);
	end

	// ---------------- final assembly and saturation
	localparam logic [NW-1:0] ONE_U = NW'(1) << FRAC_BITS;

	function automatic logic [FIELD_W-1:0] sat_sgn(input logic [NW-1:0] q, input logic neg);
		logic [NW-1:0]         m;
		logic signed [NW:0]    v;
		logic signed [NW:0]    hi;
		logic signed [NW:0]    lo;
		m = (q > ONE_U) ? ONE_U : q;
		v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
		hi = (NW+1)'((1 << (FIELD_W-1)) - 1);
		lo = -(NW+1)'(1 << (FIELD_W-1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[FIELD_W-1:0];
	endfunction

	logic [SW-1:0]      s_f;
	logic [1:0]         br_f;
	logic [2:0]         neg_f;
	logic               dgn;
	logic [NW-1:0]      diag_u;
	logic [FIELD_W-1:0] diag_q, qa, qb, qc;

	always_comb begin
		s_f = ddvs[NDV];
		br_f = dside[NDV][SIDE_W-1 -: 2];
		neg_f = dside[NDV][2:0];
		dgn = s_f == '0;
		diag_u = NW'((SW+1)'(s_f) + (SW+1)'(2) >> 2);
		diag_q = dgn ? '0 : sat_sgn(diag_u, 1'b0);
		qa = dgn ? '0 : sat_sgn(dquo[NDV][0], neg_f[2]);
		qb = dgn ? '0 : sat_sgn(dquo[NDV][1], neg_f[1]);
		qc = dgn ? '0 : sat_sgn(dquo[NDV][2], neg_f[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv[NDV];
		end
	end

	// route lanes back to x,y,z,w by branch
	always_ff @(posedge clk) begin
		if (en) begin
			branch_used <= br_f;
			degenerate <= dgn;
			case (br_f)
				BR_TRACE: begin
					quat_x <= qa; quat_y <= qb; quat_z <= qc; quat_w <= diag_q;
				end
				BR_M00: begin
					quat_x <= diag_q; quat_y <= qa; quat_z <= qb; quat_w <= qc;
				end
				BR_M11: begin
					quat_x <= qa; quat_y <= diag_q; quat_z <= qb; quat_w <= qc;
				end
				default: begin
					quat_x <= qa; quat_y <= qb; quat_z <= diag_q; quat_w <= qc;
				end
			endcase
		end
	end

endmodule
